// File: rtl/anbx_pkg.sv
// Package for the Annex B NAL unit delimiter: record types and record builders.
package anbx_pkg;

  localparam int LENGTH_BITS = 20;
  localparam int COUNT_BITS  = LENGTH_BITS + 1;

  localparam logic [COUNT_BITS-1:0] LEN_MAX   = {1'b0, {LENGTH_BITS{1'b1}}};
  localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

  localparam logic [2:0] CODE_LEN_3 = 3'd3;
  localparam logic [2:0] CODE_LEN_4 = 3'd4;

  typedef struct packed {
    logic                   run_last;
    logic                   sync_error;
    logic                   length_saturated;
    logic [4:0]             unit_type;
    logic [1:0]             ref_idc;
    logic                   forbidden_bit;
    logic [2:0]             code_length;
    logic [LENGTH_BITS-1:0] unit_length;
    logic [31:0]            unit_offset;
    logic [31:0]            unit_index;
  } rec_t;

  // One accepted byte yields up to two records; they travel together.
  typedef struct packed {
    rec_t first;
    rec_t second;
    logic two;
  } row_t;

  function automatic rec_t make_unit(input logic [31:0] idx, input logic [31:0] start,
                                     input logic [COUNT_BITS-1:0] payload,
                                     input logic [2:0] clen, input logic [7:0] hdr);
    rec_t       r;
    logic       sat;
    logic [7:0] h;
    sat = payload > LEN_MAX;
    h   = (payload != '0) ? hdr : 8'd0;
    r.run_last         = 1'b0;
    r.sync_error       = 1'b0;
    r.length_saturated = sat;
    r.unit_type        = h[4:0];
    r.ref_idc          = h[6:5];
    r.forbidden_bit    = h[7];
    r.code_length      = clen;
    r.unit_length      = sat ? {LENGTH_BITS{1'b1}} : payload[LENGTH_BITS-1:0];
    r.unit_offset      = start;
    r.unit_index       = idx;
    return r;
  endfunction

  function automatic rec_t make_error();
    rec_t r;
    r            = '0;
    r.sync_error = 1'b1;
    return r;
  endfunction

endpackage

// File: rtl/anbx_parser.sv
// Start code detector and unit tracker: state registers and record generation per byte.
module anbx_parser (
  input  logic                clk,
  input  logic                rst,
  input  logic                accept,
  input  logic [7:0]          data,
  input  logic                fin,
  output logic                push,
  output anbx_pkg::row_t      row
);

  logic [1:0]                     zero_run, zero_run_next;
  logic                           in_unit, in_unit_next;
  logic                           error_reported, error_reported_next;
  logic                           header_seen, header_seen_next;
  logic [7:0]                     header_byte, header_byte_next;
  logic [2:0]                     code_len, code_len_next;
  logic [anbx_pkg::COUNT_BITS-1:0] byte_count, byte_count_next;
  logic [31:0]                    position, position_next;
  logic [31:0]                    unit_start, unit_start_next;
  logic [31:0]                    unit_counter, unit_counter_next;

  anbx_pkg::rec_t                 rec_a, rec_b;
  logic                           a_valid, b_valid;
  logic                           start_code;
  logic [2:0]                     len;
  logic [31:0]                    start;
  logic [anbx_pkg::COUNT_BITS-1:0] zlen, payload;

  always_comb begin
    zero_run_next       = zero_run;
    in_unit_next        = in_unit;
    error_reported_next = error_reported;
    header_seen_next    = header_seen;
    header_byte_next    = header_byte;
    code_len_next       = code_len;
    byte_count_next     = byte_count;
    unit_start_next     = unit_start;
    unit_counter_next   = unit_counter;
    position_next       = position + 32'd1;
    a_valid             = 1'b0;
    b_valid             = 1'b0;
    rec_a               = anbx_pkg::make_error();
    rec_b               = anbx_pkg::make_error();

    start_code = (data == 8'd1) && zero_run[1];
    len        = (zero_run == 2'd3) ? anbx_pkg::CODE_LEN_4 : anbx_pkg::CODE_LEN_3;
    start      = (zero_run == 2'd3) ? position - 32'd3 : position - 32'd2;
    zlen       = (zero_run == 2'd3) ? anbx_pkg::COUNT_BITS'(3) : anbx_pkg::COUNT_BITS'(2);
    payload    = (byte_count >= zlen) ? byte_count - zlen : '0;

    if (start_code) begin
      if (in_unit) begin
        a_valid           = 1'b1;
        rec_a             = anbx_pkg::make_unit(unit_counter, unit_start, payload,
                                                code_len, header_byte);
        unit_counter_next = unit_counter + 32'd1;
      end else if (!error_reported && start != 32'd0) begin
        a_valid             = 1'b1;
        error_reported_next = 1'b1;
      end
      in_unit_next     = 1'b1;
      unit_start_next  = start;
      code_len_next    = len;
      byte_count_next  = '0;
      header_seen_next = 1'b0;
      header_byte_next = 8'd0;
      zero_run_next    = 2'd0;
    end else begin
      if (!in_unit && !error_reported && (data != 8'd0 || position >= 32'd3)) begin
        a_valid             = 1'b1;
        error_reported_next = 1'b1;
      end
      if (data == 8'd0) begin
        zero_run_next = (zero_run == 2'd3) ? 2'd3 : zero_run + 2'd1;
      end else begin
        zero_run_next = 2'd0;
      end
      if (in_unit) begin
        if (!header_seen) begin
          header_byte_next = data;
          header_seen_next = 1'b1;
        end
        if (byte_count != anbx_pkg::COUNT_MAX) begin
          byte_count_next = byte_count + anbx_pkg::COUNT_BITS'(1);
        end
      end
    end

    if (fin) begin
      if (in_unit_next) begin
        b_valid = 1'b1;
        rec_b   = anbx_pkg::make_unit(unit_counter_next, unit_start_next, byte_count_next,
                                      code_len_next, header_byte_next);
      end else if (!error_reported_next) begin
        b_valid = 1'b1;
      end
      zero_run_next       = 2'd0;
      in_unit_next        = 1'b0;
      error_reported_next = 1'b0;
      header_seen_next    = 1'b0;
      header_byte_next    = 8'd0;
      code_len_next       = anbx_pkg::CODE_LEN_3;
      byte_count_next     = '0;
      position_next       = 32'd0;
      unit_start_next     = 32'd0;
      unit_counter_next   = 32'd0;
    end
  end

  always_comb begin
    row.two             = a_valid && b_valid;
    row.first           = a_valid ? rec_a : rec_b;
    row.first.run_last  = !(a_valid && b_valid);
    row.second          = rec_b;
    row.second.run_last = 1'b1;
    push                = accept && (a_valid || b_valid);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      zero_run       <= 2'd0;
      in_unit        <= 1'b0;
      error_reported <= 1'b0;
      header_seen    <= 1'b0;
      header_byte    <= 8'd0;
      code_len       <= anbx_pkg::CODE_LEN_3;
      byte_count     <= '0;
      position       <= 32'd0;
      unit_start     <= 32'd0;
      unit_counter   <= 32'd0;
    end else if (accept) begin
      zero_run       <= zero_run_next;
      in_unit        <= in_unit_next;
      error_reported <= error_reported_next;
      header_seen    <= header_seen_next;
      header_byte    <= header_byte_next;
      code_len       <= code_len_next;
      byte_count     <= byte_count_next;
      position       <= position_next;
      unit_start     <= unit_start_next;
      unit_counter   <= unit_counter_next;
    end
  end

endmodule

// File: rtl/anbx_out_fifo.sv
// Two-row result buffer: stores record pairs and serializes them onto the output stream.
module anbx_out_fifo (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  anbx_pkg::row_t row_in,
  output logic           ready,
  output logic           m_valid,
  input  logic           m_ready,
  output anbx_pkg::rec_t m_rec
);

  anbx_pkg::row_t rows [2];
  logic [1:0]     cnt;
  logic           wptr;
  logic           rptr;
  logic           sub;
  logic           pop_rec;
  logic           pop_row;

  assign ready   = (cnt != 2'd2);
  assign m_valid = (cnt != 2'd0);
  assign m_rec   = sub ? rows[rptr].second : rows[rptr].first;
  assign pop_rec = m_valid && m_ready;
  assign pop_row = pop_rec && (sub || !rows[rptr].two);

  always_ff @(posedge clk) begin
    if (push) begin
      rows[wptr] <= row_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt  <= 2'd0;
      wptr <= 1'b0;
      rptr <= 1'b0;
      sub  <= 1'b0;
    end else begin
      if (push) begin
        wptr <= ~wptr;
      end
      if (pop_row) begin
        rptr <= ~rptr;
        sub  <= 1'b0;
      end else if (pop_rec) begin
        sub <= 1'b1;
      end
      if (push && !pop_row) begin
        cnt <= cnt + 2'd1;
      end else if (!push && pop_row) begin
        cnt <= cnt - 2'd1;
      end
    end
  end

  a_cnt_bound: assert property (@(posedge clk) disable iff (rst) cnt != 2'd3)
    else $error("row count overflow");
  a_no_push_full: assert property (@(posedge clk) disable iff (rst) push |-> ready)
    else $error("push into full buffer");
  a_sub_pair: assert property (@(posedge clk) disable iff (rst) sub |-> rows[rptr].two)
    else $error("second record read from single row");
  a_drain: assert property (@(posedge clk) disable iff (rst)
    (pop_row && !push) |=> cnt == $past(cnt) - 2'd1)
    else $error("row count did not drop on pop");

endmodule

// File: rtl/annexb_nal_unit_delimiter.sv
// Top level of the Annex B NAL unit delimiter: byte stream in, unit records out.
//
//   channel  dir  tdata (low bit up)                                         tuser       tlast
//   s_*      in   data_byte[7:0]                                             -           stream_end
//   m_*      out  unit_index, unit_offset, unit_length, code_length,         sync_error  run_last
//                 forbidden_bit, ref_idc, unit_type, length_saturated
//
// One byte per cycle while s_tready is high; state updates in the cycle the transaction is taken.
// A byte yielding two records is sent as two output records; input continues while a row is free.
// Synchronous reset clears parser state and the buffer; no clearing pass.
// Output stalls back up through a two-row buffer to s_tready.
module annexb_nal_unit_delimiter (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // data_byte
  input  logic        s_tlast,   // stream_end
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [95:0] m_tdata,   // unit_index, unit_offset, unit_length, code_length,
                                 // forbidden_bit, ref_idc, unit_type, length_saturated
  output logic        m_tuser,   // sync_error
  output logic        m_tlast    // run_last
);

  logic           accept;
  logic           push;
  anbx_pkg::row_t row;
  anbx_pkg::rec_t rec;

  assign accept = s_tvalid && s_tready;

  anbx_parser u_parser (
    .clk    (clk),
    .rst    (rst),
    .accept (accept),
    .data   (s_tdata),
    .fin    (s_tlast),
    .push   (push),
    .row    (row)
  );

  anbx_out_fifo u_out (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .row_in  (row),
    .ready   (s_tready),
    .m_valid (m_tvalid),
    .m_ready (m_tready),
    .m_rec   (rec)
  );

  assign m_tdata = {rec.length_saturated, rec.unit_type, rec.ref_idc, rec.forbidden_bit,
                    rec.code_length, rec.unit_length, rec.unit_offset, rec.unit_index};
  assign m_tuser = rec.sync_error;
  assign m_tlast = rec.run_last;

endmodule
